[hdl/sha1mh_pkg.sv]
// Shared types and constants for the SHA-1 message hasher.
// No dependencies; used by sha1mh_core and sha1_message_hasher.
package sha1mh_pkg;

  // Rounds in one compression and the last round index.
  localparam int unsigned Rounds = 80;
  localparam logic [6:0] LastRound = 7'(Rounds - 1);

  // Round constants, one per group of twenty rounds.
  localparam logic [31:0] K_0_19  = 32'h5a827999;
  localparam logic [31:0] K_20_39 = 32'h6ed9eba1;
  localparam logic [31:0] K_40_59 = 32'h8f1bbcdc;
  localparam logic [31:0] K_60_79 = 32'hca62c1d6;

  // First padding byte appended after the message.
  localparam logic [7:0] PadMark = 8'h80;

  // Five 32-bit words, word k in slot k, so word 0 sits in the lowest slot.
  typedef logic [4:0][31:0] word5_t;

  // Standard initial chaining value.
  localparam word5_t InitValue = {32'hc3d2e1f0, 32'h10325476, 32'h98badcfe,
                                  32'hefcdab89, 32'h67452301};

  // Requests from the sequencer to the round unit.
  typedef struct packed {
    logic        push;
    logic [31:0] word;
    logic        start;
  } core_ctrl_t;

  // Status of the round unit.
  typedef struct packed {
    logic busy;
    logic done;
  } core_stat_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LEN_HI,
    ST_LEN_LO,
    ST_ROUND,
    ST_ADD,
    ST_OUT
  } state_e;

endpackage

[hdl/sha1_message_hasher.sv]
// SHA-1 hasher top level: byte packing, padding sequencer and digest output; uses sha1mh_pkg.
// Bytes are taken one a cycle while idle; a byte that completes a 64-byte block starts the
// rounds of sha1mh_core and the chaining add, and no request is taken until they end.
// An end of message is followed by the padding, the length words and the final compression
// (an extra block at 56 held bytes or more); words go one a cycle while out_ready_i is high.
// Reset loads the standard initial value and clears the byte count and the message length.
module sha1_message_hasher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        byte_present_i,
  input  logic        end_of_message_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);

  sha1mh_pkg::state_e     state_q, state_d;
  sha1mh_pkg::word5_t     chain_q;
  sha1mh_pkg::word5_t     work;
  sha1mh_pkg::core_ctrl_t ctrl;
  sha1mh_pkg::core_stat_t stat;

  logic [23:0] acc_q;
  logic [5:0]  cnt_q;
  logic [63:0] len_q;
  logic        pad_q;
  logic        first_q;
  logic        final_q;
  logic [2:0]  out_idx_q;

  logic        accept;
  logic        feed_en;
  logic [7:0]  feed_byte;
  logic        len_push;
  logic        pad_done;
  logic        out_done;

  assign accept   = in_valid_i && in_ready_o;
  assign pad_done = (cnt_q == 6'd56) && !first_q;
  assign out_done = out_valid_o && out_ready_i && (out_idx_q == 3'd4);

  // Shared round unit.
  sha1mh_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .chain_i(chain_q),
    .work_o (work),
    .stat_o (stat)
  );

  // Sequencer outputs: handshakes, byte feed and word pushes.
  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    feed_en     = 1'b0;
    feed_byte   = data_byte_i;
    len_push    = 1'b0;
    ctrl.word   = {acc_q, feed_byte};
    case (state_q)
      sha1mh_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        feed_en    = in_valid_i && byte_present_i;
      end
      sha1mh_pkg::ST_PAD: begin
        feed_en   = !pad_done;
        feed_byte = first_q ? sha1mh_pkg::PadMark : 8'h00;
      end
      sha1mh_pkg::ST_LEN_HI: begin
        len_push = 1'b1;
      end
      sha1mh_pkg::ST_LEN_LO: begin
        len_push = 1'b1;
      end
      sha1mh_pkg::ST_OUT: begin
        out_valid_o = 1'b1;
      end
      default: begin
      end
    endcase
    if (state_q == sha1mh_pkg::ST_LEN_HI) begin
      ctrl.word = len_q[63:32];
    end else if (state_q == sha1mh_pkg::ST_LEN_LO) begin
      ctrl.word = len_q[31:0];
    end else begin
      ctrl.word = {acc_q, feed_byte};
    end
    ctrl.push  = len_push || (feed_en && (cnt_q[1:0] == 2'd3));
    ctrl.start = ctrl.push && (cnt_q[5:2] == 4'hf);
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      sha1mh_pkg::ST_IDLE: begin
        if (accept) begin
          if (ctrl.start) begin
            state_d = sha1mh_pkg::ST_ROUND;
          end else if (end_of_message_i) begin
            state_d = sha1mh_pkg::ST_PAD;
          end
        end
      end
      sha1mh_pkg::ST_PAD: begin
        if (pad_done) begin
          state_d = sha1mh_pkg::ST_LEN_HI;
        end else if (ctrl.start) begin
          state_d = sha1mh_pkg::ST_ROUND;
        end
      end
      sha1mh_pkg::ST_LEN_HI: state_d = sha1mh_pkg::ST_LEN_LO;
      sha1mh_pkg::ST_LEN_LO: state_d = sha1mh_pkg::ST_ROUND;
      sha1mh_pkg::ST_ROUND: begin
        if (stat.done) begin
          state_d = sha1mh_pkg::ST_ADD;
        end
      end
      sha1mh_pkg::ST_ADD: begin
        if (final_q) begin
          state_d = sha1mh_pkg::ST_OUT;
        end else if (pad_q) begin
          state_d = sha1mh_pkg::ST_PAD;
        end else begin
          state_d = sha1mh_pkg::ST_IDLE;
        end
      end
      sha1mh_pkg::ST_OUT: begin
        if (out_done) begin
          state_d = sha1mh_pkg::ST_IDLE;
        end
      end
      default: state_d = sha1mh_pkg::ST_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sha1mh_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Partial word: the first three bytes of a word wait here.
  always_ff @(posedge clk_i) begin
    if (feed_en) begin
      acc_q <= {acc_q[15:0], feed_byte};
    end
  end

  // Byte position in the block, message length and padding flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      len_q   <= '0;
      pad_q   <= 1'b0;
      first_q <= 1'b0;
      final_q <= 1'b0;
    end else begin
      if (feed_en) begin
        cnt_q <= cnt_q + 6'd1;
      end else if (len_push) begin
        cnt_q <= cnt_q + 6'd4;
      end
      if (state_q == sha1mh_pkg::ST_IDLE && feed_en) begin
        len_q <= len_q + 64'd8;
      end
      if (accept && end_of_message_i) begin
        pad_q   <= 1'b1;
        first_q <= 1'b1;
      end else if (state_q == sha1mh_pkg::ST_PAD && feed_en) begin
        first_q <= 1'b0;
      end
      if (state_q == sha1mh_pkg::ST_LEN_LO) begin
        final_q <= 1'b1;
      end
      if (out_done) begin
        len_q   <= '0;
        pad_q   <= 1'b0;
        final_q <= 1'b0;
      end
    end
  end

  // Chaining words: add after each compression, reload after the digest.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q <= sha1mh_pkg::InitValue;
    end else if (state_q == sha1mh_pkg::ST_ADD) begin
      for (int k = 0; k < 5; k++) begin
        chain_q[k] <= chain_q[k] + work[k];
      end
    end else if (out_done) begin
      chain_q <= sha1mh_pkg::InitValue;
    end
  end

  // Digest word index.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_idx_q <= '0;
    end else if (out_valid_o && out_ready_i) begin
      out_idx_q <= out_done ? 3'd0 : out_idx_q + 3'd1;
    end
  end

  assign digest_word_o = chain_q[out_idx_q];
  assign word_index_o  = out_idx_q;
  assign last_word_o   = (out_idx_q == 3'd4);

`ifndef ASSERT_OFF
  // A compression starts only when the last word of a block is pushed.
  a_start_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.start |-> (ctrl.push && cnt_q[5:2] == 4'hf))
    else $error("compression started on a partial block");

  // No request is taken while the round unit is working.
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.busy |-> !in_ready_o)
    else $error("request accepted during compression");

  // The digest is shown only on a block boundary, after the final compression.
  a_out_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (cnt_q == 6'd0 && final_q))
    else $error("digest shown before the final block");

  // The output channel closes only after the last word.
  a_out_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_o) |-> $past(last_word_o && out_ready_i))
    else $error("digest output stopped early");
`endif

endmodule

[hdl/sha1mh_core.sv]
// SHA-1 round unit: sixteen-word schedule shift line, working words a..e
// and the round counter. Depends on sha1mh_pkg.
module sha1mh_core (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  sha1mh_pkg::core_ctrl_t ctrl_i,
  input  sha1mh_pkg::word5_t     chain_i,
  output sha1mh_pkg::word5_t     work_o,
  output sha1mh_pkg::core_stat_t stat_o
);

  logic [15:0][31:0]  sched_q;
  sha1mh_pkg::word5_t work_q;
  logic [6:0]         rnd_q;
  logic               busy_q;

  logic [31:0] a, b, c, d, e;
  logic [31:0] f, kc, mix, t_sum;

  assign a = work_q[0];
  assign b = work_q[1];
  assign c = work_q[2];
  assign d = work_q[3];
  assign e = work_q[4];

  // Boolean function and constant for the current group of rounds.
  always_comb begin
    if (rnd_q < 7'd20) begin
      f  = (b & c) | (~b & d);
      kc = sha1mh_pkg::K_0_19;
    end else if (rnd_q < 7'd40) begin
      f  = b ^ c ^ d;
      kc = sha1mh_pkg::K_20_39;
    end else if (rnd_q < 7'd60) begin
      f  = (b & c) | (b & d) | (c & d);
      kc = sha1mh_pkg::K_40_59;
    end else begin
      f  = b ^ c ^ d;
      kc = sha1mh_pkg::K_60_79;
    end
  end

  // Next schedule word from the fixed taps of the line; slot 0 holds W[t].
  assign mix   = sched_q[13] ^ sched_q[8] ^ sched_q[2] ^ sched_q[0];
  assign t_sum = {a[26:0], a[31:27]} + f + e + kc + sched_q[0];

  // Schedule line: message words shift in from the top, and each round
  // shifts in the expanded word.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.push || busy_q) begin
      for (int i = 0; i < 15; i++) begin
        sched_q[i] <= sched_q[i+1];
      end
      sched_q[15] <= ctrl_i.push ? ctrl_i.word : {mix[30:0], mix[31]};
    end
  end

  // Working words: loaded from the chaining value at start, one round a cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      work_q <= '0;
    end else if (ctrl_i.start) begin
      work_q <= chain_i;
    end else if (busy_q) begin
      work_q[0] <= t_sum;
      work_q[1] <= a;
      work_q[2] <= {b[1:0], b[31:2]};
      work_q[3] <= c;
      work_q[4] <= d;
    end
  end

  // Round counter and busy flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rnd_q  <= '0;
      busy_q <= 1'b0;
    end else if (ctrl_i.start) begin
      rnd_q  <= '0;
      busy_q <= 1'b1;
    end else if (busy_q) begin
      if (rnd_q == sha1mh_pkg::LastRound) begin
        rnd_q  <= '0;
        busy_q <= 1'b0;
      end else begin
        rnd_q <= rnd_q + 7'd1;
      end
    end
  end

  assign work_o      = work_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = busy_q && (rnd_q == sha1mh_pkg::LastRound);

`ifndef ASSERT_OFF
  // A compression only starts while the unit is free.
  a_start_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.start |-> !busy_q)
    else $error("compression started while rounds in progress");

  // The round counter never passes the last round.
  a_rnd_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (rnd_q <= sha1mh_pkg::LastRound))
    else $error("round counter out of range");

  // Rounds begin only after a start request.
  a_busy_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_q) |-> $past(ctrl_i.start))
    else $error("round unit became busy without a start");
`endif

endmodule

[verif/sha1_message_hasher_test.sv]
// Self-checking testbench for the SHA-1 message hasher: byte requests in, five digest words out.
// Holds its own SHA-1 predictor and compares every digest word. Needs only sha1_message_hasher
// and the RTL that it depends on.
`timescale 1ns / 100ps

module sha1_message_hasher_test;

  // Standard SHA-1 chaining value, round constants and the first padding byte.
  localparam logic [31:0] IvWords [5] = '{32'h67452301, 32'hefcdab89, 32'h98badcfe,
                                          32'h10325476, 32'hc3d2e1f0};
  localparam logic [31:0] RoundK0 = 32'h5a827999;
  localparam logic [31:0] RoundK1 = 32'h6ed9eba1;
  localparam logic [31:0] RoundK2 = 32'h8f1bbcdc;
  localparam logic [31:0] RoundK3 = 32'hca62c1d6;
  localparam logic [7:0]  PadByte = 8'h80;

  // Cycles without any accepted request on either side before the run is abandoned.
  localparam int unsigned QuietLimit = 5000;
  // Length of the long output hold-off.
  localparam int unsigned HoldOffCycles = 600;
  // Cycles allowed after the last expected word, for anything stray to appear.
  localparam int unsigned TailCycles = 200;
  // Byte or end requests per idling phase of the random part, at the least.
  localparam int unsigned PhaseRequests = 30;
  // Messages per idling phase of the random part, at the least.
  localparam int unsigned PhaseMessages = 3;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_beat_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  data_byte_i;
  logic        byte_present_i;
  logic        end_of_message_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [31:0] digest_word_o;
  logic [2:0]  word_index_o;
  logic        last_word_o;

  // Predictor state: chaining words, current block, bytes held and message length in bits.
  logic [31:0] hash_words [5];
  logic [31:0] block_words [16];
  int unsigned block_fill;
  logic [63:0] message_bits;

  digest_beat_t expected_digest_q [$];

  int unsigned mismatch_count = 0;
  int unsigned requests_sent = 0;
  int unsigned messages_sent = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned ready_hold_left = 0;

  sha1_message_hasher DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .data_byte_i      (data_byte_i),
    .byte_present_i   (byte_present_i),
    .end_of_message_i (end_of_message_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .digest_word_o    (digest_word_o),
    .word_index_o     (word_index_o),
    .last_word_o      (last_word_o)
  );

  // Clock with a 2 ns period.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Predictor: back to the initial value with an empty message.
  function automatic void clear_message();
    for (int k = 0; k < 5; k++) hash_words[k] = IvWords[k];
    block_fill = 0;
    message_bits = '0;
  endfunction

  // Places a byte big-endian at position pos of the current block.
  function automatic void place_byte(input int unsigned pos, input logic [7:0] value);
    block_words[pos / 4][31 - 8 * (pos % 4) -: 8] = value;
  endfunction

  // One SHA-1 compression of the current block into the chaining words.
  function automatic void compress_block();
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, k, t, x;
    for (int i = 0; i < 16; i++) w[i] = block_words[i];
    for (int i = 16; i < 80; i++) begin
      x = w[i - 3] ^ w[i - 8] ^ w[i - 14] ^ w[i - 16];
      w[i] = {x[30:0], x[31]};
    end
    a = hash_words[0];
    b = hash_words[1];
    c = hash_words[2];
    d = hash_words[3];
    e = hash_words[4];
    for (int i = 0; i < 80; i++) begin
      if (i < 20) begin
        f = (b & c) | (~b & d);
        k = RoundK0;
      end else if (i < 40) begin
        f = b ^ c ^ d;
        k = RoundK1;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = RoundK2;
      end else begin
        f = b ^ c ^ d;
        k = RoundK3;
      end
      t = {a[26:0], a[31:27]} + f + e + k + w[i];
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = t;
    end
    hash_words[0] += a;
    hash_words[1] += b;
    hash_words[2] += c;
    hash_words[3] += d;
    hash_words[4] += e;
  endfunction

  // Works out what one accepted request does; an end of message queues five digest words.
  function automatic void predict_request(input logic [7:0] value, input logic present,
                                          input logic finish);
    digest_beat_t beat;
    if (present) begin
      place_byte(block_fill, value);
      message_bits += 64'd8;
      block_fill = (block_fill + 1) % 64;
      if (block_fill == 0) compress_block();
    end
    if (!finish) return;
    // Padding mark, zeros, and an extra block when the length no longer fits.
    place_byte(block_fill, PadByte);
    for (int unsigned p = block_fill + 1; p < 64; p++) place_byte(p, 8'h00);
    if (block_fill >= 56) begin
      compress_block();
      for (int i = 0; i < 14; i++) block_words[i] = '0;
    end
    block_words[14] = message_bits[63:32];
    block_words[15] = message_bits[31:0];
    compress_block();
    for (int i = 0; i < 5; i++) begin
      beat.word = hash_words[i];
      beat.index = 3'(i);
      beat.last = (i == 4);
      expected_digest_q.push_back(beat);
    end
    clear_message();
  endfunction

  // Offers one request, with random idle cycles first, and waits until it is accepted.
  // Called and returns at a falling edge; valid stays high for a following request.
  task automatic send_request(input logic [7:0] value, input logic present, input logic finish);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    data_byte_i <= value;
    byte_present_i <= present;
    end_of_message_i <= finish;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_request(value, present, finish);
    if (present || finish) requests_sent++;
    if (finish) messages_sent++;
    @(negedge clk_i);
  endtask

  // A whole message of random bytes, with stray empty requests now and then. The end
  // either rides on the last byte or comes as a request of its own.
  task automatic send_message(input int unsigned length);
    logic joined_end;
    joined_end = (length != 0) && ($urandom_range(1) == 1);
    for (int unsigned n = 0; n < length; n++) begin
      if ($urandom_range(9) == 0) send_request(8'($urandom), 1'b0, 1'b0);
      send_request(8'($urandom), 1'b1, joined_end && (n == length - 1));
    end
    if (!joined_end) send_request(8'($urandom), 1'b0, 1'b1);
  endtask

  // Lengths around the block and padding boundaries, otherwise mostly short messages.
  function automatic int unsigned pick_length();
    int unsigned edge_lengths [12] = '{0, 1, 55, 56, 57, 63, 64, 65, 119, 120, 127, 128};
    if ($urandom_range(9) < 2) return edge_lengths[$urandom_range(11)];
    return $urandom_range(16);
  endfunction

  // Empty message, lone bytes at the extremes, stray requests and the two ways to end.
  task automatic test_directed();
    send_request(8'($urandom), 1'b0, 1'b1);
    send_request(8'hff, 1'b0, 1'b0);
    send_request(8'h00, 1'b1, 1'b1);
    send_request(8'h61, 1'b1, 1'b0);
    send_request(8'h62, 1'b1, 1'b0);
    send_request(8'h00, 1'b0, 1'b0);
    send_request(8'h63, 1'b1, 1'b0);
    send_request(8'hff, 1'b0, 1'b1);
    send_request(8'hff, 1'b1, 1'b0);
    send_request(8'h80, 1'b1, 1'b1);
    send_request(8'h7f, 1'b0, 1'b1);
  endtask

  // Random messages under one idling setting.
  task automatic test_random_messages(input int unsigned idle_pct, input int unsigned stall_pct);
    int unsigned first_request;
    int unsigned first_message;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    first_request = requests_sent;
    first_message = messages_sent;
    while (requests_sent - first_request < PhaseRequests ||
           messages_sent - first_message < PhaseMessages)
      send_message(pick_length());
  endtask

  // The receiver holds off for a long stretch while short messages keep coming, so the
  // hasher stays on its digest output and has to refuse requests.
  task automatic test_output_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    ready_hold_left = HoldOffCycles;
    repeat (4) send_message($urandom_range(3));
    send_message(pick_length());
  endtask

  // Receiver: random stalls, or a counted hold-off when one is asked for.
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (ready_hold_left > 0) begin
        out_ready_i <= 1'b0;
        ready_hold_left--;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Each digest word is compared with the oldest expected word.
  always @(posedge clk_i) begin
    digest_beat_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_digest_q.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected digest word %h index %0d last %b", $time,
                 digest_word_o, word_index_o, last_word_o);
      end else begin
        want = expected_digest_q.pop_front();
        if (digest_word_o !== want.word) begin
          mismatch_count++;
          $display("%0t: digest_word expected %h actual %h", $time, want.word, digest_word_o);
        end
        if (word_index_o !== want.index) begin
          mismatch_count++;
          $display("%0t: word_index expected %0d actual %0d", $time, want.index,
                   word_index_o);
        end
        if (last_word_o !== want.last) begin
          mismatch_count++;
          $display("%0t: last_word expected %b actual %b", $time, want.last, last_word_o);
        end
      end
    end
  end

  // Watchdog: ends the run when nothing has been accepted on either side for too long.
  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < QuietLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("Mismatches found");
    $finish;
  end

  // Reset, the tests in turn, then the drain and the verdict.
  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    data_byte_i = '0;
    byte_present_i = 1'b0;
    end_of_message_i = 1'b0;
    for (int i = 0; i < 16; i++) block_words[i] = '0;
    clear_message();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    test_random_messages(0, 0);
    test_random_messages(59, 0);
    test_random_messages(0, 59);
    test_random_messages(11, 11);
    test_output_backpressure();

    in_valid_i <= 1'b0;
    while (expected_digest_q.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (mismatch_count == 0 && expected_digest_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
